@@ rtl/dmb_pkg.sv @@
// shared types and constants of the diagonal motion blur block
`timescale 1ns / 1ps
package dmb_pkg;

   localparam int CHAN_W      = 8;
   localparam int PIXEL_W     = 3 * CHAN_W;
   localparam int ROW_W       = 12;
   localparam int COL_OUT_W   = 10;
   localparam int WIDTH_REG_W = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int MAX_HEIGHT  = 4096;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int DIV_SHIFT   = 16;
   localparam int RECIP_W     = DIV_SHIFT + 1;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd768;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   typedef logic [PIXEL_W-1:0] pixel_type;

endpackage

@@ rtl/dmb_ram.sv @@
// generic single-write, single-read ram with registered read (read-first)
`timescale 1ns / 1ps
module dmb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/diagonal_motion_blur_5x5.sv @@
// top level: diagonal motion blur with banked line store and gather pipeline
//
//   channel   direction   handshake             payload
//   req_      in          req_valid/req_ready   red_in, green_in, blue_in
//   rsp_      out         rsp_valid/rsp_ready   red/green/blue_out, out_row, out_col,
//                                                last_of_run, frame_done
//   csr_      in          apb write/read        image_width, image_height
//
// a pixel transaction is taken every cycle unless the output is stalled or the previous pixel
// still has read rounds left; each result takes as many line store read rounds as the most
// of its taps that fall in one bank, so it takes more rounds near the top and bottom edges and
// in a single-row frame, where clamped taps share a bank.
// edge flushes emit up to (RADIUS+1)^2 results for one input; the input waits meanwhile.
// each result moves through the s1, s2 and s3 registers to the output; a stalled rsp_ready freezes the pipe.
// synchronous reset clears counters and valid flags and restores the size registers; the line store is not cleared.
`timescale 1ns / 1ps
module diagonal_motion_blur_5x5 #(
   parameter int MAX_WIDTH = 1024,
   parameter int RADIUS    = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dmb_pkg::CHAN_W-1:0]        req_red_in,
   input  logic [dmb_pkg::CHAN_W-1:0]        req_green_in,
   input  logic [dmb_pkg::CHAN_W-1:0]        req_blue_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dmb_pkg::CHAN_W-1:0]        rsp_red_out,
   output logic [dmb_pkg::CHAN_W-1:0]        rsp_green_out,
   output logic [dmb_pkg::CHAN_W-1:0]        rsp_blue_out,
   output logic [dmb_pkg::ROW_W-1:0]         rsp_out_row,
   output logic [dmb_pkg::COL_OUT_W-1:0]     rsp_out_col,
   output logic                              rsp_last_of_run,
   output logic                              rsp_frame_done,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dmb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [dmb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [dmb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int TAPS    = 2 * RADIUS + 1;
   localparam int CW      = $clog2(MAX_WIDTH);
   localparam int BW      = $clog2(TAPS);
   localparam int RW      = dmb_pkg::ROW_W;
   localparam int SUM_W   = $clog2(TAPS * 255 + 1);
   localparam int XEXT_W  = (CW > dmb_pkg::COL_OUT_W) ? CW : dmb_pkg::COL_OUT_W;
   localparam int RST_W   = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
   localparam logic [dmb_pkg::RECIP_W-1:0] RECIP =
      dmb_pkg::RECIP_W'(((1 << dmb_pkg::DIV_SHIFT) + TAPS - 1) / TAPS);
   localparam logic [TAPS-1:0] ALL_TAPS = {TAPS{1'b1}};

   // ---------------- configuration ----------------
   logic [dmb_pkg::WIDTH_REG_W-1:0]  width_reg_ff, width_reg_in;
   logic [dmb_pkg::HEIGHT_REG_W-1:0] height_reg_ff, height_reg_in;
   logic [CW-1:0]                    w_m1_ff, w_m1_in;
   logic [RW-1:0]                    h_m1_ff, h_m1_in;
   logic                             csr_write;
   dmb_pkg::reg_index_type           csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = dmb_pkg::reg_index_type'(csr_paddr[2]);

   always_comb begin
      width_reg_in  = width_reg_ff;
      height_reg_in = height_reg_ff;
      w_m1_in       = w_m1_ff;
      h_m1_in       = h_m1_ff;
      if (csr_write) begin
         case (csr_index)
            dmb_pkg::REG_IMAGE_WIDTH: begin
               width_reg_in = csr_pwdata[dmb_pkg::WIDTH_REG_W-1:0];
               if (width_reg_in == '0) begin
                  w_m1_in = '0;
               end else if (32'(width_reg_in) > 32'(MAX_WIDTH)) begin
                  w_m1_in = CW'(MAX_WIDTH - 1);
               end else begin
                  w_m1_in = CW'(width_reg_in - 1'b1);
               end
            end
            dmb_pkg::REG_IMAGE_HEIGHT: begin
               height_reg_in = csr_pwdata[dmb_pkg::HEIGHT_REG_W-1:0];
               if (height_reg_in == '0) begin
                  h_m1_in = '0;
               end else if (32'(height_reg_in) > 32'(dmb_pkg::MAX_HEIGHT)) begin
                  h_m1_in = RW'(dmb_pkg::MAX_HEIGHT - 1);
               end else begin
                  h_m1_in = RW'(height_reg_in - 1'b1);
               end
            end
            default: begin
               width_reg_in = width_reg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff  <= dmb_pkg::WIDTH_RESET;
         height_reg_ff <= dmb_pkg::HEIGHT_RESET;
         w_m1_ff       <= CW'(RST_W - 1);
         h_m1_ff       <= RW'(dmb_pkg::HEIGHT_RESET - 1'b1);
      end else begin
         width_reg_ff  <= width_reg_in;
         height_reg_ff <= height_reg_in;
         w_m1_ff       <= w_m1_in;
         h_m1_ff       <= h_m1_in;
      end
   end

   always_comb begin
      case (csr_index)
         dmb_pkg::REG_IMAGE_WIDTH:  csr_prdata = dmb_pkg::CSR_DATA_W'(width_reg_ff);
         dmb_pkg::REG_IMAGE_HEIGHT: csr_prdata = dmb_pkg::CSR_DATA_W'(height_reg_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // ---------------- raster position ----------------
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [BW-1:0] rmod_ff, rmod_in;
   logic          accept;
   logic          stall;

   assign accept = req_valid && req_ready;

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      rmod_in = rmod_ff;
      if (csr_write) begin
         row_in  = '0;
         col_in  = '0;
         rmod_in = '0;
      end else if (accept) begin
         if (col_ff == w_m1_ff) begin
            col_in = '0;
            if (row_ff == h_m1_ff) begin
               row_in  = '0;
               rmod_in = '0;
            end else begin
               row_in  = row_ff + 1'b1;
               rmod_in = (rmod_ff == BW'(TAPS - 1)) ? '0 : rmod_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         rmod_ff <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         rmod_ff <= rmod_in;
      end
   end

   // results caused by the incoming pixel: a row-major block of coordinates
   logic          job_valid;
   logic [RW-1:0] job_y_lo, job_y_hi;
   logic [CW-1:0] job_x_lo, job_x_hi;
   logic          job_x_ok;

   always_comb begin
      job_x_ok = 1'b1;
      if (col_ff == w_m1_ff) begin
         job_x_lo = (32'(w_m1_ff) > RADIUS) ? CW'(w_m1_ff - CW'(RADIUS)) : '0;
         job_x_hi = w_m1_ff;
      end else begin
         job_x_lo = CW'(col_ff - CW'(RADIUS));
         job_x_hi = job_x_lo;
         job_x_ok = (32'(col_ff) >= RADIUS);
      end
      if (row_ff == h_m1_ff) begin
         job_y_lo = (32'(h_m1_ff) > RADIUS) ? RW'(h_m1_ff - RW'(RADIUS)) : '0;
         job_y_hi = h_m1_ff;
         job_valid = job_x_ok;
      end else begin
         job_y_lo = RW'(row_ff - RW'(RADIUS));
         job_y_hi = job_y_lo;
         job_valid = job_x_ok && (32'(row_ff) >= RADIUS);
      end
   end

   // ---------------- result generator and tap gather ----------------
   logic            gen_active_ff, gen_active_in;
   logic [RW-1:0]   gen_y_ff, gen_y_in, gen_y_hi_ff, gen_y_hi_in;
   logic [CW-1:0]   gen_x_ff, gen_x_in, gen_x_lo_ff, gen_x_lo_in, gen_x_hi_ff, gen_x_hi_in;
   logic [RW-1:0]   gen_r_ff, gen_r_in;
   logic [BW-1:0]   gen_rmod_ff, gen_rmod_in;
   logic [TAPS-1:0] pend_ff, pend_in;

   logic                    issue;
   logic [TAPS-1:0]         grant;
   logic [TAPS-1:0]         bank_used;
   logic [CW-1:0]           bank_addr [TAPS];
   logic [RW-1:0]           tap_yy [TAPS];
   logic [CW-1:0]           tap_xx [TAPS];
   logic [BW-1:0]           tap_bank [TAPS];
   logic                    last_round;
   logic                    run_end;
   logic                    gen_done_now;

   assign issue = gen_active_ff && !stall;

   always_comb begin
      logic signed [RW+1:0] ys;
      logic signed [CW+1:0] xs;
      logic [RW-1:0]        diff;
      logic [BW:0]          bsum;
      for (int i = 0; i < TAPS; i++) begin
         ys = $signed({2'b00, gen_y_ff}) + (RW + 2)'(i - RADIUS);
         xs = $signed({2'b00, gen_x_ff}) + (CW + 2)'(i - RADIUS);
         if (ys < 0) begin
            tap_yy[i] = '0;
         end else if (ys > $signed({2'b00, h_m1_ff})) begin
            tap_yy[i] = h_m1_ff;
         end else begin
            tap_yy[i] = ys[RW-1:0];
         end
         if (xs < 0) begin
            tap_xx[i] = '0;
         end else if (xs > $signed({2'b00, w_m1_ff})) begin
            tap_xx[i] = w_m1_ff;
         end else begin
            tap_xx[i] = xs[CW-1:0];
         end
         // rows back from the newest row, at most 2*RADIUS
         diff = gen_r_ff - tap_yy[i];
         if ({1'b0, gen_rmod_ff} >= {1'b0, diff[BW-1:0]}) begin
            bsum = {1'b0, gen_rmod_ff} - {1'b0, diff[BW-1:0]};
         end else begin
            bsum = {1'b0, gen_rmod_ff} + (BW + 1)'(TAPS) - {1'b0, diff[BW-1:0]};
         end
         tap_bank[i] = bsum[BW-1:0];
      end
   end

   // lowest pending tap wins each bank; the rest wait a round
   always_comb begin
      grant     = '0;
      bank_used = '0;
      for (int b = 0; b < TAPS; b++) begin
         bank_addr[b] = '0;
      end
      for (int i = 0; i < TAPS; i++) begin
         if (pend_ff[i] && !bank_used[tap_bank[i]]) begin
            grant[i]                = 1'b1;
            bank_used[tap_bank[i]]  = 1'b1;
            bank_addr[tap_bank[i]]  = tap_xx[i];
         end
      end
   end

   assign last_round   = (pend_ff & ~grant) == '0;
   assign run_end      = (gen_x_ff == gen_x_hi_ff) && (gen_y_ff == gen_y_hi_ff);
   assign gen_done_now = issue && last_round && run_end;
   assign req_ready    = !stall && (!gen_active_ff || gen_done_now);

   always_comb begin
      gen_active_in = gen_active_ff;
      gen_y_in      = gen_y_ff;
      gen_y_hi_in   = gen_y_hi_ff;
      gen_x_in      = gen_x_ff;
      gen_x_lo_in   = gen_x_lo_ff;
      gen_x_hi_in   = gen_x_hi_ff;
      gen_r_in      = gen_r_ff;
      gen_rmod_in   = gen_rmod_ff;
      pend_in       = pend_ff;
      if (issue) begin
         if (last_round) begin
            pend_in = ALL_TAPS;
            if (gen_x_ff == gen_x_hi_ff) begin
               if (gen_y_ff == gen_y_hi_ff) begin
                  gen_active_in = 1'b0;
               end else begin
                  gen_y_in = gen_y_ff + 1'b1;
                  gen_x_in = gen_x_lo_ff;
               end
            end else begin
               gen_x_in = gen_x_ff + 1'b1;
            end
         end else begin
            pend_in = pend_ff & ~grant;
         end
      end
      if (accept && job_valid) begin
         gen_active_in = 1'b1;
         gen_y_in      = job_y_lo;
         gen_y_hi_in   = job_y_hi;
         gen_x_in      = job_x_lo;
         gen_x_lo_in   = job_x_lo;
         gen_x_hi_in   = job_x_hi;
         gen_r_in      = row_ff;
         gen_rmod_in   = rmod_ff;
         pend_in       = ALL_TAPS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_active_ff <= 1'b0;
         pend_ff       <= ALL_TAPS;
      end else begin
         gen_active_ff <= gen_active_in;
         pend_ff       <= pend_in;
      end
      gen_y_ff    <= gen_y_in;
      gen_y_hi_ff <= gen_y_hi_in;
      gen_x_ff    <= gen_x_in;
      gen_x_lo_ff <= gen_x_lo_in;
      gen_x_hi_ff <= gen_x_hi_in;
      gen_r_ff    <= gen_r_in;
      gen_rmod_ff <= gen_rmod_in;
   end

   // ---------------- line store banks ----------------
   dmb_pkg::pixel_type bank_data [TAPS];
   dmb_pkg::pixel_type wr_pixel;

   assign wr_pixel = {req_red_in, req_green_in, req_blue_in};

   for (genvar b = 0; b < TAPS; b++) begin : g_bank
      dmb_ram #(
         .WIDTH (dmb_pkg::PIXEL_W),
         .DEPTH (MAX_WIDTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (accept && (rmod_ff == BW'(b))),
         .wr_addr (col_ff),
         .wr_data (wr_pixel),
         .rd_en   (issue && bank_used[b]),
         .rd_addr (bank_addr[b]),
         .rd_data (bank_data[b])
      );
   end

   // ---------------- sum, divide, output ----------------
   logic                s1_valid_ff, s1_first_ff, s1_last_ff, s1_run_ff, s1_done_ff;
   logic [TAPS-1:0]     s1_mask_ff;
   logic [RW-1:0]       s1_y_ff;
   logic [CW-1:0]       s1_x_ff;
   logic [SUM_W-1:0]    acc_ff [3];
   logic [SUM_W-1:0]    sum_now [3];

   logic                s2_valid_ff, s2_run_ff, s2_done_ff;
   logic [SUM_W-1:0]    s2_sum_ff [3];
   logic [RW-1:0]       s2_y_ff;
   logic [CW-1:0]       s2_x_ff;

   logic                s3_valid_ff, s3_run_ff, s3_done_ff;
   logic [dmb_pkg::CHAN_W-1:0] s3_chan_ff [3];
   logic [RW-1:0]       s3_y_ff;
   logic [CW-1:0]       s3_x_ff;
   logic [XEXT_W-1:0]   s3_x_ext;

   assign stall = s3_valid_ff && !rsp_ready;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum_now[ch] = s1_first_ff ? '0 : acc_ff[ch];
         for (int b = 0; b < TAPS; b++) begin
            if (s1_mask_ff[b]) begin
               sum_now[ch] = sum_now[ch] +
                  SUM_W'(bank_data[b][dmb_pkg::CHAN_W*(2-ch) +: dmb_pkg::CHAN_W]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [SUM_W+dmb_pkg::RECIP_W-1:0] prod;
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (!stall) begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff && s1_last_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      if (!stall) begin
         s1_first_ff <= (pend_ff == ALL_TAPS);
         s1_last_ff  <= last_round;
         s1_run_ff   <= last_round && run_end;
         s1_done_ff  <= (gen_y_ff == h_m1_ff) && (gen_x_ff == w_m1_ff);
         s1_mask_ff  <= bank_used;
         s1_y_ff     <= gen_y_ff;
         s1_x_ff     <= gen_x_ff;
         for (int ch = 0; ch < 3; ch++) begin
            if (s1_valid_ff) begin
               acc_ff[ch] <= sum_now[ch];
            end
            s2_sum_ff[ch] <= sum_now[ch];
            // floor(sum / taps) by reciprocal multiply
            prod = s2_sum_ff[ch] * RECIP;
            s3_chan_ff[ch] <= prod[dmb_pkg::DIV_SHIFT +: dmb_pkg::CHAN_W];
         end
         s2_run_ff  <= s1_run_ff;
         s2_done_ff <= s1_done_ff;
         s2_y_ff    <= s1_y_ff;
         s2_x_ff    <= s1_x_ff;
         s3_run_ff  <= s2_run_ff;
         s3_done_ff <= s2_done_ff;
         s3_y_ff    <= s2_y_ff;
         s3_x_ff    <= s2_x_ff;
      end
   end

   assign s3_x_ext        = XEXT_W'(s3_x_ff);
   assign rsp_valid       = s3_valid_ff;
   assign rsp_red_out     = s3_chan_ff[0];
   assign rsp_green_out   = s3_chan_ff[1];
   assign rsp_blue_out    = s3_chan_ff[2];
   assign rsp_out_row     = s3_y_ff;
   assign rsp_out_col     = s3_x_ext[dmb_pkg::COL_OUT_W-1:0];
   assign rsp_last_of_run = s3_run_ff;
   assign rsp_frame_done  = s3_done_ff;

   // ---------------- assertions ----------------
   a_issue_grants: assert property (@(posedge clock) disable iff (reset)
      issue |-> (grant != '0))
      else $error("read round issued without any tap granted");

   a_last_reaches_sum: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_ff && !stall) |=> s2_valid_ff)
      else $error("completed gather did not reach the divide stage");

   a_frame_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> rsp_last_of_run)
      else $error("frame end result is not the last of its run");

   a_no_accept_while_gathering: assert property (@(posedge clock) disable iff (reset)
      (accept && gen_active_ff) |-> gen_done_now)
      else $error("pixel taken while results of the previous pixel still pending");

endmodule
